@@ sv/fenwick_tree_prefix_sum_core_macros.svh @@
// Assertion macros for the Fenwick tree prefix-sum core.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef FENWICK_TREE_PREFIX_SUM_CORE_MACROS_SVH
`define FENWICK_TREE_PREFIX_SUM_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked outside reset.
`define FTPS_ASSERT_IMPLIES(name, clk_s, rst_s, ante, cons) \
    name: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error("ftps: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define FTPS_ASSERT_NEXT(name, clk_s, rst_s, ante, cons) \
    name: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error("ftps: next-cycle check failed");

`else

`define FTPS_ASSERT_IMPLIES(name, clk_s, rst_s, ante, cons)
`define FTPS_ASSERT_NEXT(name, clk_s, rst_s, ante, cons)

`endif

`endif

@@ sv/ftps_pkg.sv @@
// Shared types and constants for the Fenwick tree prefix-sum core.
// No dependencies; imported by every ftps module.
package ftps_pkg;

    localparam int IDX_W   = 10;
    localparam int DATA_W  = 32;
    localparam int TYPE_W  = 2;
    localparam int Q_DEPTH = 2;

    localparam int              DEF_TREE_SIZE    = 1024;
    localparam logic [IDX_W-1:0] DEF_TOP_POSITION = 10'd1023;

    // Request kinds; REQ_NONE also covers an update at position zero.
    typedef enum logic [TYPE_W-1:0] {
        REQ_ADD    = 2'd0,
        REQ_PREFIX = 2'd1,
        REQ_RANGE  = 2'd2,
        REQ_NONE   = 2'd3
    } req_kind_t;

    typedef struct packed {
        req_kind_t               kind;
        logic [IDX_W-1:0]        idx_a;
        logic [IDX_W-1:0]        idx_b;
        logic [DATA_W-1:0]       delta;
    } cmd_t;

    typedef enum logic [1:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_WALK,
        BK_FINISH
    } back_state_t;

    typedef struct packed {
        logic clearing;
        logic idle;
    } back_status_t;

endpackage

@@ sv/ftps_front.sv @@
// Front end: takes request transactions, clamps indices, classifies the kind.
// Depends on ftps_pkg.
module ftps_front #(
    parameter int TREE_SIZE = ftps_pkg::DEF_TREE_SIZE
) (
    input  logic                              req_valid,
    output logic                              req_ready,
    input  logic [ftps_pkg::TYPE_W-1:0]       req_type,
    input  logic [ftps_pkg::IDX_W-1:0]        first_index,
    input  logic [ftps_pkg::IDX_W-1:0]        second_index,
    input  logic signed [ftps_pkg::DATA_W-1:0] delta,
    input  logic                              clearing,
    output logic                              push_valid,
    input  logic                              push_ready,
    output ftps_pkg::cmd_t                    push_cmd
);
    import ftps_pkg::*;

    localparam logic [31:0] MAX_IDX = 32'(TREE_SIZE - 1);

    logic [IDX_W-1:0] idx_a;
    logic [IDX_W-1:0] idx_b;
    req_kind_t        kind;

    // indices beyond the tree saturate to the last position
    always_comb
    begin
        idx_a = first_index;
        idx_b = second_index;
        if (32'(first_index) > MAX_IDX)
        begin
            idx_a = MAX_IDX[IDX_W-1:0];
        end
        if (32'(second_index) > MAX_IDX)
        begin
            idx_b = MAX_IDX[IDX_W-1:0];
        end
    end

    always_comb
    begin
        unique case (req_type)
            REQ_ADD:    kind = (idx_a == '0) ? REQ_NONE : REQ_ADD;
            REQ_PREFIX: kind = REQ_PREFIX;
            REQ_RANGE:  kind = REQ_RANGE;
            default:    kind = REQ_NONE;
        endcase
    end

    assign push_cmd.kind  = kind;
    assign push_cmd.idx_a = idx_a;
    assign push_cmd.idx_b = idx_b;
    assign push_cmd.delta = delta;

    assign push_valid = req_valid && !clearing;
    assign req_ready  = push_ready && !clearing;

endmodule

@@ sv/ftps_queue.sv @@
// Short command queue between the front end and the tree walker.
// Depends on ftps_pkg.
module ftps_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    output logic           push_ready,
    input  ftps_pkg::cmd_t push_cmd,
    output logic           pop_valid,
    input  logic           pop_ready,
    output ftps_pkg::cmd_t pop_cmd
);
    import ftps_pkg::*;

    localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CNT_W = $clog2(Q_DEPTH + 1);

    cmd_t              slots_reg [Q_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg,  count_next;
    logic              do_push, do_pop;

    assign push_ready = (count_reg != CNT_W'(Q_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = slots_reg[rd_ptr_reg];

    assign do_push = push_valid && push_ready;
    assign do_pop  = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

@@ sv/ftps_back.sv @@
// Back end: tree memory, clearing pass, up/down walker and result register.
// Depends on ftps_pkg.
module ftps_back #(
    parameter int TREE_SIZE = ftps_pkg::DEF_TREE_SIZE
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic [ftps_pkg::IDX_W-1:0]         top_position,
    input  logic                               cmd_valid,
    output logic                               cmd_ready,
    input  ftps_pkg::cmd_t                     cmd,
    output logic                               rsp_valid,
    input  logic                               rsp_ready,
    output logic signed [ftps_pkg::DATA_W-1:0] total,
    output ftps_pkg::back_status_t             status
);
    import ftps_pkg::*;

    localparam int AW = $clog2(TREE_SIZE);
    localparam int PW = AW + 1;
    localparam logic [31:0] MAX_POS = 32'(TREE_SIZE - 1);

    back_state_t state_reg, state_next;

    logic [DATA_W-1:0] mem [TREE_SIZE];
    logic [DATA_W-1:0] rdata_reg;

    req_kind_t          kind_reg,    kind_next;
    logic [IDX_W-1:0]   idx_a_reg,   idx_a_next;
    logic [DATA_W-1:0]  delta_reg,   delta_next;
    logic [PW-1:0]      pos_reg,     pos_next;
    logic               phase_reg,   phase_next;
    logic [DATA_W-1:0]  acc_reg,     acc_next;
    logic               rd_pend_reg, rd_pend_next;
    logic               rd_sub_reg,  rd_sub_next;
    logic [AW-1:0]      rd_addr_reg, rd_addr_next;
    logic [AW-1:0]      clr_addr_reg, clr_addr_next;
    logic               rsp_valid_reg, rsp_valid_next;
    logic [DATA_W-1:0]  total_reg,   total_next;

    logic [31:0]        limit_wide;
    logic [PW-1:0]      limit;
    logic [PW-1:0]      low_bit;
    logic               up_walk;
    logic               can_issue;
    logic               clear_last;
    logic               walk_done;
    logic               rsp_load;
    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [DATA_W-1:0]  mem_wdata;

    // climb ceiling: configured top, capped at the last tree position
    assign limit_wide = (32'(top_position) > MAX_POS) ? MAX_POS : 32'(top_position);
    assign limit      = limit_wide[PW-1:0];

    assign low_bit    = pos_reg & (~pos_reg + PW'(1));
    assign up_walk    = (kind_reg == REQ_ADD);
    assign can_issue  = (state_reg == BK_WALK) && (pos_reg != '0)
                        && (!up_walk || (pos_reg <= limit));
    assign clear_last = (clr_addr_reg == AW'(TREE_SIZE - 1));
    assign walk_done  = !can_issue && !rd_pend_reg
                        && !((kind_reg == REQ_RANGE) && !phase_reg);
    assign rsp_load   = (state_reg == BK_FINISH) && (!rsp_valid_reg || rsp_ready);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_CLEAR:
            begin
                if (clear_last)
                begin
                    state_next = BK_IDLE;
                end
            end
            BK_IDLE:
            begin
                if (cmd_valid)
                begin
                    state_next = (cmd.kind == REQ_NONE) ? BK_FINISH : BK_WALK;
                end
            end
            BK_WALK:
            begin
                if (walk_done)
                begin
                    state_next = BK_FINISH;
                end
            end
            BK_FINISH:
            begin
                if (rsp_load)
                begin
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        kind_next      = kind_reg;
        idx_a_next     = idx_a_reg;
        delta_next     = delta_reg;
        pos_next       = pos_reg;
        phase_next     = phase_reg;
        acc_next       = acc_reg;
        rd_pend_next   = 1'b0;
        rd_sub_next    = rd_sub_reg;
        rd_addr_next   = rd_addr_reg;
        clr_addr_next  = clr_addr_reg;
        total_next     = total_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        mem_we         = 1'b0;
        mem_waddr      = rd_addr_reg;
        mem_wdata      = rdata_reg + delta_reg;
        cmd_ready      = (state_reg == BK_IDLE);

        unique case (state_reg)
            BK_CLEAR:
            begin
                mem_we        = 1'b1;
                mem_waddr     = clr_addr_reg;
                mem_wdata     = '0;
                clr_addr_next = clr_addr_reg + 1'b1;
            end
            BK_IDLE:
            begin
                if (cmd_valid)
                begin
                    kind_next  = cmd.kind;
                    idx_a_next = cmd.idx_a;
                    delta_next = cmd.delta;
                    phase_next = 1'b0;
                    acc_next   = '0;
                    pos_next   = (cmd.kind == REQ_RANGE) ? PW'(cmd.idx_b) : PW'(cmd.idx_a);
                end
            end
            BK_WALK:
            begin
                // retire the read issued last cycle
                if (rd_pend_reg)
                begin
                    if (up_walk)
                    begin
                        mem_we = 1'b1;
                    end
                    else if (rd_sub_reg)
                    begin
                        acc_next = acc_reg - rdata_reg;
                    end
                    else
                    begin
                        acc_next = acc_reg + rdata_reg;
                    end
                end
                // issue the next read of the walk
                if (can_issue)
                begin
                    rd_pend_next = 1'b1;
                    rd_sub_next  = (kind_reg == REQ_RANGE) && phase_reg;
                    rd_addr_next = pos_reg[AW-1:0];
                    pos_next     = up_walk ? pos_reg + low_bit : pos_reg - low_bit;
                end
                else if ((kind_reg == REQ_RANGE) && !phase_reg)
                begin
                    phase_next = 1'b1;
                    pos_next   = PW'(idx_a_reg);
                end
            end
            BK_FINISH:
            begin
                if (rsp_load)
                begin
                    total_next     = acc_reg;
                    rsp_valid_next = 1'b1;
                end
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_CLEAR;
            clr_addr_reg  <= '0;
            rd_pend_reg   <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            rd_pend_reg   <= rd_pend_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg    <= kind_next;
        idx_a_reg   <= idx_a_next;
        delta_reg   <= delta_next;
        pos_reg     <= pos_next;
        phase_reg   <= phase_next;
        acc_reg     <= acc_next;
        rd_sub_reg  <= rd_sub_next;
        rd_addr_reg <= rd_addr_next;
        total_reg   <= total_next;
    end

    // tree storage: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (can_issue)
        begin
            rdata_reg <= mem[pos_reg[AW-1:0]];
        end
    end

    assign rsp_valid       = rsp_valid_reg;
    assign total           = total_reg;
    assign status.clearing = (state_reg == BK_CLEAR);
    assign status.idle     = (state_reg == BK_IDLE);

endmodule

@@ sv/fenwick_tree_prefix_sum_core.sv @@
// Top level of the Fenwick tree prefix-sum core: config register and wiring.
// Depends on ftps_pkg, ftps_front, ftps_queue, ftps_back and the macros header.
//
// Binary indexed tree of TREE_SIZE wrapping 32-bit partial sums. Each request
// transaction is a point add (type 0), a prefix sum (type 1) or a range sum
// (type 2, prefix(second_index) - prefix(first_index)); every request gives
// exactly one response transaction, with total = 0 for adds and for type 3.
// Indices above TREE_SIZE-1 saturate. An add at position 0 changes nothing.
// After reset the tree memory is zeroed by a clearing pass over all TREE_SIZE
// entries (1024 by default), during which req_ready stays low.
// Afterwards the tree memory, with one registered read and one write per
// cycle, sets the pace: the walker visits one tree entry per cycle. An add
// or a prefix sum visits up to log2(TREE_SIZE) entries (10 at the default
// size); a range sum visits up to 2*log2(TREE_SIZE) entries (20) over its
// two walks. An add at position 0 and type 3 skip the walk and go straight
// to the finish state. The walker takes a new request only in its idle
// state. A response that is not taken holds the walker in its finish state.
// A two-entry command queue lets new requests be taken while the walker is
// busy or a response waits in the output register.
// top_position is written through cfg_wr_en/cfg_wr_data. The user must write
// it only while the block is idle; the block itself does not enforce this. It
// caps how far an add climbs (values above TREE_SIZE-1 act as TREE_SIZE-1,
// zero makes adds no-ops).
`include "fenwick_tree_prefix_sum_core_macros.svh"

module fenwick_tree_prefix_sum_core #(
    parameter int TREE_SIZE = ftps_pkg::DEF_TREE_SIZE
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // configuration
    input  logic                               cfg_wr_en,
    input  logic [ftps_pkg::IDX_W-1:0]         cfg_wr_data,
    // request channel
    input  logic                               req_valid,
    output logic                               req_ready,
    input  logic [ftps_pkg::TYPE_W-1:0]        req_type,
    input  logic [ftps_pkg::IDX_W-1:0]         first_index,
    input  logic [ftps_pkg::IDX_W-1:0]         second_index,
    input  logic signed [ftps_pkg::DATA_W-1:0] delta,
    // response channel
    output logic                               rsp_valid,
    input  logic                               rsp_ready,
    output logic signed [ftps_pkg::DATA_W-1:0] total
);
    import ftps_pkg::*;

    logic [IDX_W-1:0] top_position_reg, top_position_next;

    logic         push_valid, push_ready;
    cmd_t         push_cmd;
    logic         q_valid, q_ready;
    cmd_t         q_cmd;
    back_status_t back_status;

    // configuration register
    assign top_position_next = cfg_wr_en ? cfg_wr_data : top_position_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_position_reg <= DEF_TOP_POSITION;
        end
        else
        begin
            top_position_reg <= top_position_next;
        end
    end

    // front end: clamp and classify each request transaction
    ftps_front #(
        .TREE_SIZE (TREE_SIZE)
    ) u_front (
        .req_valid    (req_valid),
        .req_ready    (req_ready),
        .req_type     (req_type),
        .first_index  (first_index),
        .second_index (second_index),
        .delta        (delta),
        .clearing     (back_status.clearing),
        .push_valid   (push_valid),
        .push_ready   (push_ready),
        .push_cmd     (push_cmd)
    );

    // decoupling queue
    ftps_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_cmd    (q_cmd)
    );

    // back end: tree memory and walker
    ftps_back #(
        .TREE_SIZE (TREE_SIZE)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .top_position (top_position_reg),
        .cmd_valid    (q_valid),
        .cmd_ready    (q_ready),
        .cmd          (q_cmd),
        .rsp_valid    (rsp_valid),
        .rsp_ready    (rsp_ready),
        .total        (total),
        .status       (back_status)
    );

    // no request transaction may slip in while the tree is being zeroed
    `FTPS_ASSERT_IMPLIES(a_no_accept_in_clear, clk, rst_n, back_status.clearing, !req_ready)
    // a command handed to the walker always leaves it busy next cycle
    `FTPS_ASSERT_NEXT(a_pop_makes_busy, clk, rst_n, q_valid && q_ready, !back_status.idle)
    // the clearing pass ends straight in the idle state
    `FTPS_ASSERT_NEXT(a_clear_ends_idle, clk, rst_n, back_status.clearing, |back_status)

endmodule

@@ bench/fenwick_tree_prefix_sum_core_tb.sv @@
// Self-checking testbench for fenwick_tree_prefix_sum_core: directed and random requests.
// It predicts every total with its own copy of the tree and checks each response in order.
// Depends on ftps_pkg and the core RTL only.
module fenwick_tree_prefix_sum_core_tb;

    import ftps_pkg::*;

    localparam int CLK_PERIOD     = 20;
    localparam int TREE_SIZE      = DEF_TREE_SIZE;
    // Slowest run: a clearing pass, then ~1300 transactions, each with a walk,
    // sender idling and receiver stalls. The limit leaves a wide margin.
    localparam int TIMEOUT_CYCLES = 400000;
    // Worst request is a range sum over two full-depth walks, plus the queue.
    localparam int SETTLE_CYCLES  = 60;

    // Receiver stall patterns, switched at random during the run.
    typedef enum logic [1:0] {
        RX_OPEN,        // always ready
        RX_SKIP_FOURTH, // stalls one cycle in four
        RX_COIN,        // random per cycle
        RX_TRICKLE      // ready one cycle in eight
    } rx_pattern_t;

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_wr_en;
    logic [IDX_W-1:0]         cfg_wr_data;
    logic                     req_valid;
    logic                     req_ready;
    logic [TYPE_W-1:0]        req_type;
    logic [IDX_W-1:0]         first_index;
    logic [IDX_W-1:0]         second_index;
    logic signed [DATA_W-1:0] delta;
    logic                     rsp_valid;
    logic                     rsp_ready;
    logic signed [DATA_W-1:0] total;

    // Predicted tree contents and the add climb limit last written.
    logic [DATA_W-1:0] tree_sums [0:TREE_SIZE-1];
    logic [IDX_W-1:0]  climb_limit;

    // Totals still owed by the core, oldest first.
    logic [DATA_W-1:0] expected_totals [$];

    int unsigned error_count;
    int unsigned rsp_count;
    int unsigned burst_left;

    fenwick_tree_prefix_sum_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .req_valid    (req_valid),
        .req_ready    (req_ready),
        .req_type     (req_type),
        .first_index  (first_index),
        .second_index (second_index),
        .delta        (delta),
        .rsp_valid    (rsp_valid),
        .rsp_ready    (rsp_ready),
        .total        (total)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #(CLK_PERIOD / 2) clk = ~clk;
        end
    end

    // Hard stop in case the core hangs or drops a response.
    initial
    begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                   input logic [DATA_W-1:0] want);
        error_count++;
        $display("ERROR response %0d: %s: got %h, expected %h", rsp_count, what, got, want);
    endtask

    // ---------------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------------

    // Downward walk: sum the entries, dropping the lowest set bit each step.
    function automatic logic [DATA_W-1:0] prefix_of(input logic [IDX_W-1:0] idx);
        logic [DATA_W-1:0] acc;
        int                i;
        acc = '0;
        i   = int'(idx);
        while (i != 0)
        begin
            acc += tree_sums[i];
            i   -= i & -i;
        end
        return acc;
    endfunction

    // Upward climb from pos by its lowest set bit, capped by climb_limit.
    // climb_limit is 10 bits, so it never exceeds TREE_SIZE-1 here.
    // Position zero never enters the loop, so that add is a no-op.
    function automatic void apply_add(input logic [IDX_W-1:0] pos,
                                      input logic [DATA_W-1:0] amount);
        int p;
        p = int'(pos);
        while (p != 0 && p <= climb_limit)
        begin
            tree_sums[p] += amount;
            p            += p & -p;
        end
    endfunction

    // Total owed for one accepted request; updates the predicted tree for adds.
    // Index saturation is not modeled: 10-bit indices never exceed TREE_SIZE-1.
    function automatic logic [DATA_W-1:0] tree_response(input req_kind_t kind,
                                                        input logic [IDX_W-1:0] idx_a,
                                                        input logic [IDX_W-1:0] idx_b,
                                                        input logic [DATA_W-1:0] amount);
        case (kind)
            REQ_ADD:
            begin
                apply_add(idx_a, amount);
                return '0;
            end
            REQ_PREFIX: return prefix_of(idx_a);
            // Lower bound above upper bound still subtracts; the result wraps.
            REQ_RANGE:  return prefix_of(idx_b) - prefix_of(idx_a);
            default:    return '0;
        endcase
    endfunction

    // ---------------------------------------------------------------------
    // Request side
    // ---------------------------------------------------------------------

    // Sends one request transaction. The sender runs in bursts: at the end of a
    // burst valid drops for a random gap; within a burst valid stays high and
    // only the payload changes, so back-to-back transactions are exercised.
    task automatic send_request(input req_kind_t kind, input logic [IDX_W-1:0] idx_a,
                                input logic [IDX_W-1:0] idx_b, input logic [DATA_W-1:0] amount);
        if (burst_left == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            // An occasional long burst gives stretches with no sender idling.
            burst_left = ($urandom_range(0, 5) == 0) ? 64 : $urandom_range(1, 12);
        end
        req_valid    <= 1'b1;
        req_type     <= kind;
        first_index  <= idx_a;
        second_index <= idx_b;
        delta        <= amount;
        do
            @(posedge clk);
        while (!req_ready);
        burst_left--;
        expected_totals = {expected_totals, tree_response(kind, idx_a, idx_b, amount)};
    endtask

    // Ends the current burst and waits for every outstanding response.
    // Called in the step of the last acceptance, so valid drops right after it.
    task automatic drain_responses();
        req_valid  <= 1'b0;
        burst_left = 0;
        while (expected_totals.size() != 0)
            @(posedge clk);
    endtask

    // Register write, only with the core idle. Every request yields a response,
    // so an empty expectation queue means the walker is done.
    task automatic write_top_position(input logic [IDX_W-1:0] value);
        drain_responses();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        climb_limit = value;
    endtask

    // Mostly uniform, with extra weight near both ends of the tree.
    function automatic logic [IDX_W-1:0] pick_index();
        case ($urandom_range(0, 9))
            0, 1:    return IDX_W'($urandom_range(0, 15));
            2:       return IDX_W'($urandom_range(TREE_SIZE - 16, TREE_SIZE - 1));
            default: return IDX_W'($urandom_range(0, TREE_SIZE - 1));
        endcase
    endfunction

    // ---------------------------------------------------------------------
    // Response side: stall pattern and in-order check
    // ---------------------------------------------------------------------

    initial
    begin : response_checker
        int unsigned       stall_tick;
        rx_pattern_t       pattern;
        logic [DATA_W-1:0] want;
        stall_tick = 0;
        pattern    = RX_OPEN;
        rsp_ready  = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_valid && rsp_ready)
            begin
                rsp_count++;
                if (expected_totals.size() == 0)
                begin
                    report_mismatch("response with nothing outstanding", total, 'x);
                end
                else
                begin
                    want = expected_totals.pop_front();
                    if (total !== want)
                        report_mismatch("total", total, want);
                end
            end
            stall_tick++;
            if (stall_tick % 80 == 0)
                pattern = rx_pattern_t'($urandom_range(0, 3));
            case (pattern)
                RX_OPEN:        rsp_ready <= 1'b1;
                RX_SKIP_FOURTH: rsp_ready <= (stall_tick % 4) != 0;
                RX_COIN:        rsp_ready <= 1'($urandom_range(0, 1));
                default:        rsp_ready <= (stall_tick % 8) == 7;
            endcase
        end
    end

    // ---------------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------------

    // Field extremes, every request kind and the boundary cases at full climb.
    task automatic test_boundary_requests();
        write_top_position(DEF_TOP_POSITION);
        send_request(REQ_ADD,    10'd1,    10'd0,    32'h7fff_ffff);
        send_request(REQ_ADD,    10'd1023, 10'd1023, 32'h8000_0000);
        // add at position zero must not touch the tree
        send_request(REQ_ADD,    10'd0,    10'd512,  32'h1234_5678);
        send_request(REQ_ADD,    10'd512,  10'd3,    32'hffff_ffff);
        // entry 1 wraps past the positive maximum
        send_request(REQ_ADD,    10'd1,    10'd0,    32'h0000_0001);
        send_request(REQ_PREFIX, 10'd0,    10'd1023, 32'hffff_ffff);
        send_request(REQ_PREFIX, 10'd1,    10'd0,    32'h0);
        send_request(REQ_PREFIX, 10'd1023, 10'd0,    32'h0);
        send_request(REQ_PREFIX, 10'd512,  10'd511,  32'h5555_aaaa);
        send_request(REQ_RANGE,  10'd0,    10'd1023, 32'h0);
        // lower bound above upper bound: the difference wraps
        send_request(REQ_RANGE,  10'd1023, 10'd0,    32'h0);
        send_request(REQ_RANGE,  10'd600,  10'd600,  32'h0);
        // unused request code: no state change, zero total
        send_request(REQ_NONE,   10'd1023, 10'd1023, 32'hffff_ffff);
        send_request(REQ_ADD,    10'd768,  10'd0,    32'h0000_0001);
        send_request(REQ_PREFIX, 10'd1023, 10'd1023, 32'h0);
        send_request(REQ_RANGE,  10'd1,    10'd1022, 32'haaaa_5555);
    endtask

    // A zero climb limit turns every add into a no-op.
    task automatic test_top_position_zero();
        write_top_position(10'd0);
        send_request(REQ_ADD,    10'd1,    10'd0, 32'h0000_0005);
        send_request(REQ_ADD,    10'd1023, 10'd0, 32'h0000_0005);
        send_request(REQ_PREFIX, 10'd1023, 10'd0, 32'h0);
    endtask

    // Limit of one: only entry 1 can change.
    task automatic test_top_position_one();
        write_top_position(10'd1);
        send_request(REQ_ADD,    10'd1,    10'd0, 32'h0000_0003);
        send_request(REQ_ADD,    10'd2,    10'd0, 32'h0000_0009);
        send_request(REQ_PREFIX, 10'd1023, 10'd0, 32'h0);
        send_request(REQ_RANGE,  10'd0,    10'd2, 32'h0);
    endtask

    // Random mix, add-heavy so queries see a well-populated tree. Ignored fields
    // are randomized too so every input bit toggles.
    task automatic test_random_traffic(input logic [IDX_W-1:0] limit, input int count);
        req_kind_t         kind;
        logic [DATA_W-1:0] amount;
        int unsigned       roll;
        write_top_position(limit);
        repeat (count)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 40)
                kind = REQ_ADD;
            else if (roll < 65)
                kind = REQ_PREFIX;
            else if (roll < 93)
                kind = REQ_RANGE;
            else
                kind = REQ_NONE;
            case ($urandom_range(0, 9))
                0:       amount = 32'h8000_0000;
                1:       amount = 32'h7fff_ffff;
                2:       amount = 32'hffff_ffff;
                default: amount = $urandom();
            endcase
            send_request(kind, pick_index(), pick_index(), amount);
        end
    endtask

    // ---------------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------------

    initial
    begin
        rst_n        = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_wr_data  = '0;
        req_valid    = 1'b0;
        req_type     = REQ_NONE;
        first_index  = '0;
        second_index = '0;
        delta        = '0;
        climb_limit  = DEF_TOP_POSITION;
        error_count  = 0;
        rsp_count    = 0;
        burst_left   = 0;
        for (int i = 0; i < TREE_SIZE; i++)
            tree_sums[i] = '0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // The core clears its tree after reset; req_ready holds off meanwhile.
        test_boundary_requests();
        test_top_position_zero();
        test_top_position_one();
        test_random_traffic(10'd1023, 300);
        test_random_traffic(10'd255, 250);
        test_random_traffic(10'($urandom_range(2, 1022)), 300);
        test_random_traffic(10'd1, 80);
        test_random_traffic(10'd1023, 300);

        drain_responses();
        // Any stray response after the drain is flagged by the checker.
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+sv
sv/ftps_pkg.sv
sv/ftps_front.sv
sv/ftps_queue.sv
sv/ftps_back.sv
sv/fenwick_tree_prefix_sum_core.sv
bench/fenwick_tree_prefix_sum_core_tb.sv
